// ===== design/utf8s_pkg.sv =====
// Shared types and constants for the UTF-8 stream sanitizer.
// Used by utf8s_check, utf8s_window and utf8_stream_sanitizer; depends on nothing.
package utf8s_pkg;

   localparam int WIN_DEPTH = 4;
   localparam int WIN_IDX_W = 2;
   localparam int CNT_W     = 3;
   localparam int CP_W      = 21;

   typedef logic [7:0]       byte_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [CP_W-1:0]  cp_type;

   localparam byte_type REPLACE_CHAR = 8'h3F;
   localparam byte_type LEAD2_LO     = 8'hC2;
   localparam byte_type LEAD2_HI     = 8'hDF;
   localparam byte_type LEAD3_LO     = 8'hE0;
   localparam byte_type LEAD3_HI     = 8'hEF;
   localparam byte_type LEAD4_LO     = 8'hF0;
   localparam byte_type LEAD4_HI     = 8'hF4;
   localparam byte_type CONT_MASK    = 8'hC0;
   localparam byte_type CONT_TAG     = 8'h80;

   localparam cp_type MIN_CP2 = 21'h00080;
   localparam cp_type MIN_CP3 = 21'h00800;
   localparam cp_type MIN_CP4 = 21'h10000;
   localparam cp_type SURR_LO = 21'h0D800;
   localparam cp_type SURR_HI = 21'h0DFFF;
   localparam cp_type CP_MAX  = 21'h10FFFF;

   // What to do with the byte at the head of the window.
   typedef enum logic [1:0] {
      ACT_PASS    = 2'd0,
      ACT_REPLACE = 2'd1,
      ACT_WAIT    = 2'd2,
      ACT_SEQ     = 2'd3
   } action_type;

   typedef struct packed {
      action_type action;
      logic [1:0] extra;   // continuation bytes of an accepted sequence
   } verdict_type;

   typedef struct packed {
      logic     append;
      logic     drop;
      byte_type data;
   } win_ctrl_type;

endpackage

// ===== design/utf8s_check.sv =====
// Head-of-window checker: classifies the oldest pending byte and its sequence.
// Depends on utf8s_pkg.
module utf8s_check (
   input  utf8s_pkg::byte_type    win_bytes [utf8s_pkg::WIN_DEPTH],
   input  utf8s_pkg::count_type   win_count,
   input  logic                   last,
   output utf8s_pkg::verdict_type verdict
);

   utf8s_pkg::byte_type  head;
   logic [1:0]           n;
   utf8s_pkg::cp_type    min_cp;
   utf8s_pkg::cp_type    cp;
   utf8s_pkg::count_type need;
   logic                 c1_ok;
   logic                 c2_ok;
   logic                 c3_ok;
   logic                 seq_ok;

   assign head  = win_bytes[0];
   assign c1_ok = (win_bytes[1] & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_TAG;
   assign c2_ok = (win_bytes[2] & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_TAG;
   assign c3_ok = (win_bytes[3] & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_TAG;
   assign need  = {1'b0, n} + 3'd1;

   always_comb begin
      n      = 2'd0;
      min_cp = '0;
      if (head inside {[utf8s_pkg::LEAD2_LO:utf8s_pkg::LEAD2_HI]}) begin
         n      = 2'd1;
         min_cp = utf8s_pkg::MIN_CP2;
      end else if (head inside {[utf8s_pkg::LEAD3_LO:utf8s_pkg::LEAD3_HI]}) begin
         n      = 2'd2;
         min_cp = utf8s_pkg::MIN_CP3;
      end else if (head inside {[utf8s_pkg::LEAD4_LO:utf8s_pkg::LEAD4_HI]}) begin
         n      = 2'd3;
         min_cp = utf8s_pkg::MIN_CP4;
      end
   end

   always_comb begin
      case (n)
         2'd1:    cp = {10'd0, head[4:0], win_bytes[1][5:0]};
         2'd2:    cp = {5'd0, head[3:0], win_bytes[1][5:0], win_bytes[2][5:0]};
         2'd3:    cp = {head[2:0], win_bytes[1][5:0], win_bytes[2][5:0],
                        win_bytes[3][5:0]};
         default: cp = '0;
      endcase
   end

   assign seq_ok = c1_ok && (n < 2'd2 || c2_ok) && (n < 2'd3 || c3_ok)
                   && cp >= min_cp
                   && !(cp >= utf8s_pkg::SURR_LO && cp <= utf8s_pkg::SURR_HI)
                   && cp <= utf8s_pkg::CP_MAX;

   always_comb begin
      verdict.extra = n;
      if (!head[7]) begin
         verdict.action = utf8s_pkg::ACT_PASS;
      end else if (n == 2'd0) begin
         verdict.action = utf8s_pkg::ACT_REPLACE;
      end else if (win_count < need) begin
         // Incomplete sequence: hold it unless the stream ends here.
         verdict.action = last ? utf8s_pkg::ACT_REPLACE : utf8s_pkg::ACT_WAIT;
      end else if (seq_ok) begin
         verdict.action = utf8s_pkg::ACT_SEQ;
      end else begin
         verdict.action = utf8s_pkg::ACT_REPLACE;
      end
   end

endmodule

// ===== design/utf8s_window.sv =====
// Lookahead window: four pending bytes, oldest first, with append and drop-head.
// Depends on utf8s_pkg.
module utf8s_window (
   input  logic                    clock,
   input  logic                    reset,
   input  utf8s_pkg::win_ctrl_type ctrl,
   output utf8s_pkg::byte_type     win_bytes [utf8s_pkg::WIN_DEPTH],
   output utf8s_pkg::count_type    win_count
);

   utf8s_pkg::byte_type  win_ff [utf8s_pkg::WIN_DEPTH];
   utf8s_pkg::byte_type  win_in [utf8s_pkg::WIN_DEPTH];
   utf8s_pkg::count_type count_ff;
   utf8s_pkg::count_type count_in;

   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      if (ctrl.append) begin
         win_in[count_ff[utf8s_pkg::WIN_IDX_W-1:0]] = ctrl.data;
         count_in = count_ff + 3'd1;
      end else if (ctrl.drop) begin
         for (int i = 0; i < utf8s_pkg::WIN_DEPTH - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign win_bytes = win_ff;
   assign win_count = count_ff;

endmodule

// ===== design/utf8_stream_sanitizer.sv =====
// UTF-8 stream sanitizer top level: sequencer, output register and the
// window and checker instances. Depends on utf8s_pkg, utf8s_check, utf8s_window.
//
// The block takes one byte beat on the req_ channel, appends it to a four-byte
// lookahead window and then walks the window head under a two-state sequencer,
// giving out exactly one rsp_ beat per input byte, in order. ASCII bytes pass
// unchanged; a well-formed multibyte sequence (correct continuations, shortest
// form, no surrogate, at most 10FFFF) passes whole; otherwise only the leading
// byte turns into '?' and the bytes behind it are checked again from the start.
// A valid lead whose continuations have not arrived yet is held back until they
// do, and a beat with req_last set flushes the window, so rsp_last marks the
// last byte given out for that beat. The single head checker and the one-beat
// output register set the pace: one result beat per cycle while rsp_ready is
// high, and req_ready is low while the window is being drained. The output
// register lets the next byte be accepted while the last result still waits
// to be taken.
module utf8_stream_sanitizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic       rsp_last
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EVAL = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Bytes of an accepted sequence that still have to go out unchanged.
   logic [1:0] pass_ff;
   logic [1:0] pass_in;
   logic       last_ff;
   logic       last_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   utf8s_pkg::byte_type rsp_byte_ff;
   utf8s_pkg::byte_type rsp_byte_in;
   logic                rsp_last_ff;
   logic                rsp_last_in;

   utf8s_pkg::win_ctrl_type ctrl;
   utf8s_pkg::byte_type     win_bytes [utf8s_pkg::WIN_DEPTH];
   utf8s_pkg::count_type    win_count;
   utf8s_pkg::verdict_type  verdict;

   logic                slot_free;
   logic                emit_go;
   utf8s_pkg::byte_type emit_byte;

   utf8s_window u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .win_bytes (win_bytes),
      .win_count (win_count)
   );

   utf8s_check u_check (
      .win_bytes (win_bytes),
      .win_count (win_count),
      .last      (last_ff),
      .verdict   (verdict)
   );

   // The output register can take a new beat when empty or being drained now.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;
      ctrl.data    = req_byte;
      emit_go      = 1'b0;
      emit_byte    = win_bytes[0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.append = 1'b1;
               last_in     = req_last;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (pass_ff != 2'd0) begin
               // Continuation bytes of a sequence already found good.
               if (slot_free) begin
                  emit_go = 1'b1;
                  pass_in = pass_ff - 2'd1;
               end
            end else begin
               case (verdict.action)
                  utf8s_pkg::ACT_WAIT: begin
                     state_in = S_IDLE;
                  end
                  utf8s_pkg::ACT_PASS: begin
                     emit_go = slot_free;
                  end
                  utf8s_pkg::ACT_REPLACE: begin
                     emit_go   = slot_free;
                     emit_byte = utf8s_pkg::REPLACE_CHAR;
                  end
                  utf8s_pkg::ACT_SEQ: begin
                     emit_go = slot_free;
                     if (slot_free) begin
                        pass_in = verdict.extra;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end

            if (emit_go) begin
               ctrl.drop    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = emit_byte;
               // The beat that empties the window closes a flushing input beat.
               rsp_last_in  = last_ff && (win_count == 3'd1);
               if (win_count == 3'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
